// File: rtl/core/sorted_table_insert_unit_macros.svh
// ----------------------------------------------------------------------------
// Sorted table insert unit: assertion macros
// Shared property wrappers for the checker. All are clocked on a rising edge
// and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_INSERT_UNIT_MACROS_SVH
`define SORTED_TABLE_INSERT_UNIT_MACROS_SVH

// same-cycle implication
`define STIU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STIU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/stiu_pkg.sv
// ----------------------------------------------------------------------------
// stiu_pkg
// Types and fixed field widths for the sorted table insert unit.
// ----------------------------------------------------------------------------
package stiu_pkg;

    localparam int KEY_W     = 31;
    localparam int PAYLOAD_W = 64;
    localparam int ENTRY_W   = KEY_W + PAYLOAD_W;
    localparam int OUT_W     = 9;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [PAYLOAD_W-1:0] payload_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [OUT_W-1:0]  position;
        logic [OUT_W-1:0]  total;
    } result_t;

endpackage

// File: rtl/core/stiu_ram.sv
// ----------------------------------------------------------------------------
// stiu_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module stiu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/stiu_seq.sv
// ----------------------------------------------------------------------------
// stiu_seq
// Search and shift sequencer: binary search over the RAM, then a one-slot
// move of every later entry, then the write of the new record.
// ----------------------------------------------------------------------------
module stiu_seq #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  stiu_pkg::key_t                   record_key,
    input  stiu_pkg::payload_t               record_payload,
    output logic                             ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ram_waddr,
    output logic [stiu_pkg::ENTRY_W-1:0]     ram_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ram_raddr,
    input  logic [stiu_pkg::ENTRY_W-1:0]     ram_rdata,
    output logic                             res_valid,
    input  logic                             res_ready,
    output stiu_pkg::result_t                res
);

    import stiu_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] ONE  = CW'(1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT,
        S_WRITE,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    key_t           key_reg, key_next;
    payload_t       payload_reg, payload_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [CW-1:0]  hi_reg, hi_next;
    logic [CW-1:0]  mid_reg, mid_next;
    logic [CW-1:0]  src_reg, src_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  count_reg, count_next;
    status_t        status_reg, status_next;

    logic [CW-1:0]  mid_w;
    logic [CW-1:0]  cnt_dec_w;
    logic [CW-1:0]  src_dec_w;
    logic [CW-1:0]  src_inc_w;
    key_t           probe_key;

    assign mid_w     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign cnt_dec_w = count_reg - ONE;
    assign src_dec_w = src_reg - ONE;
    assign src_inc_w = src_reg + ONE;
    assign probe_key = ram_rdata[ENTRY_W-1:PAYLOAD_W];

    assign in_stall     = (state_reg != S_IDLE);
    assign res_valid    = (state_reg == S_DONE);
    assign res.status   = status_reg;
    assign res.position = OUT_W'(pos_reg);
    assign res.total    = OUT_W'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        src_next     = src_reg;
        pos_next     = pos_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = {key_reg, payload_reg};
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next     = record_key;
                    payload_next = record_payload;
                    lo_next      = '0;
                    hi_next      = count_reg;
                    state_next   = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_raddr  = mid_w[AW-1:0];
                    mid_next   = mid_w;
                    state_next = S_CMP;
                end
                else
                begin
                    pos_next = lo_reg;
                    if (count_reg == FULL)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if (count_reg == lo_reg)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        // start the move at the top entry
                        ram_raddr  = cnt_dec_w[AW-1:0];
                        src_next   = cnt_dec_w;
                        state_next = S_SHIFT;
                    end
                end
            end
            S_CMP:
            begin
                if (probe_key == key_reg)
                begin
                    pos_next    = mid_reg;
                    status_next = ST_DUPLICATE;
                    state_next  = S_DONE;
                end
                else
                begin
                    if (key_reg < probe_key)
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + ONE;
                    end
                    state_next = S_PROBE;
                end
            end
            S_SHIFT:
            begin
                // data of src arrives now; next read two slots below the write
                ram_we    = 1'b1;
                ram_waddr = src_inc_w[AW-1:0];
                ram_wdata = ram_rdata;
                if (src_reg == pos_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    ram_raddr = src_dec_w[AW-1:0];
                    src_next  = src_dec_w;
                end
            end
            S_WRITE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = pos_reg[AW-1:0];
                ram_wdata   = {key_reg, payload_reg};
                count_next  = count_reg + ONE;
                status_next = ST_INSERTED;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            key_reg     <= '0;
            payload_reg <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            mid_reg     <= '0;
            src_reg     <= '0;
            pos_reg     <= '0;
            status_reg  <= ST_INSERTED;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            key_reg     <= key_next;
            payload_reg <= payload_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            mid_reg     <= mid_next;
            src_reg     <= src_next;
            pos_reg     <= pos_next;
            status_reg  <= status_next;
        end
    end

endmodule

// File: rtl/core/sorted_table_insert_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_insert_unit
// Keeps up to TABLE_DEPTH key/payload records sorted by ascending key.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries record_key and record_payload.
//   Output channel (out_valid/out_stall) returns one transaction per input:
//   status (inserted, duplicate, full), insert_position and entry_total.
//   One item is processed at a time; in_stall is high from acceptance until
//   the result is handed to the output register.
//   Processing per item: each binary search probe is a RAM read plus a
//   compare, up to ceil(log2(n+1)) probes for n stored entries, then each
//   entry from position upward is moved up one slot (n - position moves),
//   then the new record is written and the result is reported. The shift
//   rate is set by the single RAM write port.
//   A finished result waits in the output register while the next item is
//   accepted; a stalled receiver holds the result stable.
//   Reset empties the table at once (entry count cleared); RAM contents
//   are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_table_insert_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [stiu_pkg::KEY_W-1:0]   record_key,
    input  logic [stiu_pkg::PAYLOAD_W-1:0] record_payload,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic [stiu_pkg::OUT_W-1:0]   insert_position,
    output logic [stiu_pkg::OUT_W-1:0]   entry_total
);

    import stiu_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;
    logic                res_valid;
    logic                res_ready;
    result_t             res;

    logic                out_valid_reg, out_valid_next;
    result_t             out_res_reg, out_res_next;

    stiu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stiu_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .record_key     (record_key),
        .record_payload (record_payload),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    assign res_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg <= out_res_next;
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_res_reg.status;
    assign insert_position = out_res_reg.position;
    assign entry_total     = out_res_reg.total;

endmodule

// File: rtl/core/stiu_checker.sv
// ----------------------------------------------------------------------------
// stiu_checker
// Port-level checks for the sorted table insert unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_table_insert_unit_macros.svh"

module stiu_checker #(
    parameter int TABLE_DEPTH = 256
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [1:0]                   status,
    input logic [stiu_pkg::OUT_W-1:0]   insert_position,
    input logic [stiu_pkg::OUT_W-1:0]   entry_total
);

    import stiu_pkg::*;

    localparam logic [OUT_W-1:0] FULL_TOTAL = OUT_W'(TABLE_DEPTH);
    localparam logic             NO_WRAP    = (TABLE_DEPTH < 512);

    // stalled result transaction must hold
    `STIU_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(status) && $stable(insert_position) && $stable(entry_total),
        "stalled result changed")

    // one item at a time: busy right after an accepted transaction
    `STIU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
        "input accepted while previous item in flight")

    // a full report carries the whole depth as total
    `STIU_ASSERT_NOW(a_full_total, clk, rst_n, out_valid && (status == ST_FULL),
        entry_total == FULL_TOTAL, "full status with short table")

    // an insert lands inside the occupied range
    `STIU_ASSERT_NOW(a_insert_range, clk, rst_n,
        NO_WRAP && out_valid && (status == ST_INSERTED),
        (entry_total != '0) && (insert_position < entry_total),
        "insert position outside table")

endmodule

bind sorted_table_insert_unit stiu_checker #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_stiu_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .insert_position (insert_position),
    .entry_total     (entry_total)
);
